// ----- src/lpcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lpcs_pkg;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_COMMIT = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef struct packed {
        req_t               req_type;
        logic signed [23:0] excitation;
        logic        [4:0]  coeff_index;
        logic signed [23:0] coeff_value;
        logic        [5:0]  new_order;
        logic signed [23:0] new_gain;
        logic               smooth_enable;
        logic               gain_enable;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_sample;
        logic               diverged;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_DSTART,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_sub;
        logic acc_clr;
    } mac_ctrl_t;

    localparam int COEF_W = 24;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 33;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int FRAC_SHIFT = 16;
    localparam logic signed [23:0] UNITY_GAIN = 24'sd65536;

endpackage
`default_nettype wire

// ----- src/lpcs_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpcs_divider import lpcs_pkg::*; #(
    parameter int DIVISOR = 64,
    parameter int RW = 7,
    parameter int QW = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [RW+QW-1:0]   dividend,
    output logic                    done,
    output logic [QW-1:0]           quotient
);
    localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;
    localparam int SH = $clog2(DIVISOR);
    localparam int YW = QW + 1;
    localparam int MW = YW + 1;
    localparam longint Q0 = (longint'(1) << QW) / DIVISOR;
    localparam longint R0 = (longint'(1) << QW) % DIVISOR;
    localparam longint RECIP = (longint'(1) << (YW + SH)) / DIVISOR + 1;
    localparam logic [QW:0]   Q0_C = (QW+1)'(Q0);
    localparam logic [RW-1:0] R0_C = RW'(R0);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [YW-1:0]       y_reg, y_next;
    logic [QW-1:0]       base_reg, base_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [RW-1:0]       xh;
    logic [QW-1:0]       xl;
    logic [RW+QW:0]      base_full;
    logic [YW+MW-1:0]    scaled;

    assign xh        = dividend[RW+QW-1:QW];
    assign xl        = dividend[QW-1:0];
    assign base_full = (RW+QW+1)'(xh) * (RW+QW+1)'(Q0_C);
    assign scaled    = (YW+MW)'(y_reg) * (YW+MW)'(RECIP_C);

    always_comb begin
        busy_next = 1'b0;
        done_next = 1'b0;
        y_next    = y_reg;
        base_next = base_reg;
        quo_next  = quo_reg;
        if (start) begin
            if (IS_POW2) begin
                quo_next  = QW'(dividend >> SH);
                done_next = 1'b1;
            end else begin
                y_next    = YW'(xh) * YW'(R0_C) + YW'(xl);
                base_next = base_full[QW-1:0];
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            quo_next  = base_reg + QW'(scaled >> (YW + SH));
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        y_reg    <= y_next;
        base_reg <= base_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/lpcs_mac_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpcs_mac_unit import lpcs_pkg::*; #(
    parameter int ACC_W = 61
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mac_ctrl_t                 ctrl,
    input  wire logic signed [MUL_A_W-1:0] mul_a,
    input  wire logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [PROD_W-1:0]       prod,
    output logic signed [ACC_W-1:0]        acc,
    output logic                           acc_busy
);
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     pend_reg;
    logic                     sub_reg;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.acc_clr) begin
            acc_next = '0;
        end else if (pend_reg) begin
            acc_next = sub_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ctrl.mul_en && ctrl.acc_en;
        end
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
            sub_reg  <= ctrl.acc_sub;
        end
        acc_reg <= acc_next;
    end

    assign prod     = prod_reg;
    assign acc      = acc_reg;
    assign acc_busy = pend_reg;

endmodule
`default_nettype wire

// ----- src/lpc_allpole_synthesis_filter_top.sv -----
// Channel  | Ports                        | Carries
// input    | s_valid s_ready s_payload    | sample, coefficient write, commit, clear
// result   | m_valid m_ready m_payload    | one synthesized sample per sample request
// config   | cfg_valid cfg_ready cfg_data | divergence limit
// Non-sample requests leave s_ready high. A sample of active order N runs N + 1 terms
// through ST_TERM to ST_FIN before the next ready; while fading each term adds a multiply
// and a constant division (ST_DSTART, ST_DIV): a shift when SMOOTH_LEN is a power of two,
// else a reciprocal multiply. Term and fade multiplies share the MAC multiplier;
// passthrough skips to ST_FIN. Reset is synchronous and clears all banks.
// A result waiting on m_ready stalls only the next sample's final state, ST_FIN.
`timescale 1ns / 1ps
`default_nettype none
module lpc_allpole_synthesis_filter_top import lpcs_pkg::*; #(
    parameter int TAP_LIMIT = 32,
    parameter int SMOOTH_LEN = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_payload,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_payload,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [30:0] cfg_data
);
    localparam int OW = $clog2(TAP_LIMIT + 1);
    localparam int AW = (TAP_LIMIT > 1) ? $clog2(TAP_LIMIT) : 1;
    localparam int CW = $clog2(SMOOTH_LEN + 1);
    localparam int ACC_W = 56 + $clog2(TAP_LIMIT + 1);
    localparam int SW = ACC_W - FRAC_SHIFT;

    state_t                   state_reg, state_next;
    logic [OW-1:0]            idx_reg, idx_next;
    logic [OW-1:0]            order_reg;
    logic [CW-1:0]            fade_reg;
    logic [CW-1:0]            c_reg;
    logic signed [23:0]       e_reg;
    logic                     pass_reg, pass_next;
    logic [30:0]              limit_reg;
    logic signed [23:0]       cur_gain_reg;
    logic signed [23:0]       prev_gain_reg;
    logic signed [23:0]       pend_coef_reg [TAP_LIMIT];
    logic signed [23:0]       cur_coef_reg  [TAP_LIMIT];
    logic signed [23:0]       prev_coef_reg [TAP_LIMIT];
    logic signed [31:0]       hist_reg      [TAP_LIMIT];
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg, out_next;

    logic [AW-1:0]            tap;
    logic signed [23:0]       now_val, prev_val, b_val;
    logic signed [24:0]       d_val, q25, b25;
    logic                     d_neg;
    logic [23:0]              d_mag;
    mac_ctrl_t                mac_ctrl;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic                     acc_busy;
    logic                     div_start, div_done;
    logic [23:0]              div_quo;
    logic signed [SW-1:0]     s_val;
    logic signed [31:0]       s32;
    logic signed [32:0]       s33, mag;
    logic                     ovf, diverge;
    logic                     fin_fire, accept;
    logic [OW-1:0]            new_p;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign tap      = AW'(idx_reg - 1'b1);
    assign now_val  = (idx_reg == '0) ? cur_gain_reg : cur_coef_reg[tap];
    assign prev_val = (idx_reg == '0) ? prev_gain_reg : prev_coef_reg[tap];
    assign d_val    = 25'(prev_val) - 25'(now_val);
    assign d_neg    = d_val < 0;
    assign d_mag    = d_neg ? 24'(-d_val) : 24'(d_val);
    assign q25      = signed'({1'b0, div_quo});
    assign b25      = 25'(now_val) + (d_neg ? -q25 : q25);
    assign b_val    = (c_reg == '0) ? now_val : b25[23:0];

    assign s_val   = acc[ACC_W-1:FRAC_SHIFT];
    assign s32     = s_val[31:0];
    assign ovf     = s_val != SW'(s32);
    assign s33     = 33'(s32);
    assign mag     = (s33 < 0) ? -s33 : s33;
    assign diverge = ovf || ($unsigned(mag) > 33'(limit_reg));

    assign new_p = ({1'b0, s_payload.new_order} > 7'(TAP_LIMIT)) ? OW'(TAP_LIMIT)
                                                                 : OW'(s_payload.new_order);
    assign fin_fire = (state_reg == ST_FIN) && !acc_busy && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        mac_ctrl       = '0;
        mul_a          = 25'(b_val);
        mul_b          = (idx_reg == '0) ? 33'(e_reg) : 33'(hist_reg[tap]);
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_payload.req_type == REQ_SAMPLE) begin
                    idx_next         = '0;
                    mac_ctrl.acc_clr = 1'b1;
                    if (order_reg == '0) begin
                        pass_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        pass_next  = 1'b0;
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                if (c_reg == '0) begin
                    mac_ctrl.mul_en  = 1'b1;
                    mac_ctrl.acc_en  = 1'b1;
                    mac_ctrl.acc_sub = idx_reg != '0;
                    if (idx_reg == order_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    mul_a           = signed'({1'b0, d_mag});
                    mul_b           = signed'(33'(c_reg));
                    mac_ctrl.mul_en = 1'b1;
                    state_next      = ST_DSTART;
                end
            end
            ST_DSTART: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    mac_ctrl.mul_en  = 1'b1;
                    mac_ctrl.acc_en  = 1'b1;
                    mac_ctrl.acc_sub = idx_reg != '0;
                    if (idx_reg == order_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_TERM;
                    end
                end
            end
            ST_FIN: begin
                if (fin_fire) begin
                    out_valid_next = 1'b1;
                    if (pass_reg) begin
                        out_next.out_sample = 32'(e_reg);
                        out_next.diverged   = 1'b0;
                    end else begin
                        out_next.out_sample = diverge ? 32'sd0 : s32;
                        out_next.diverged   = diverge;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= 31'h7FFF_FFFF;
            order_reg     <= '0;
            fade_reg      <= '0;
            c_reg         <= '0;
            cur_gain_reg  <= '0;
            prev_gain_reg <= '0;
            for (int i = 0; i < TAP_LIMIT; i++) begin
                pend_coef_reg[i] <= '0;
                cur_coef_reg[i]  <= '0;
                prev_coef_reg[i] <= '0;
                hist_reg[i]      <= '0;
            end
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (accept) begin
                case (s_payload.req_type)
                    REQ_WRITE: begin
                        if ({2'b0, s_payload.coeff_index} < 7'(TAP_LIMIT)) begin
                            pend_coef_reg[AW'(s_payload.coeff_index)] <= s_payload.coeff_value;
                        end
                    end
                    REQ_COMMIT: begin
                        if (s_payload.smooth_enable && order_reg != '0) begin
                            for (int i = 0; i < TAP_LIMIT; i++) begin
                                prev_coef_reg[i] <= cur_coef_reg[i];
                            end
                            prev_gain_reg <= cur_gain_reg;
                            fade_reg      <= CW'(SMOOTH_LEN);
                        end else begin
                            fade_reg <= '0;
                        end
                        for (int i = 0; i < TAP_LIMIT; i++) begin
                            if (i < int'(new_p)) begin
                                cur_coef_reg[i] <= pend_coef_reg[i];
                            end
                        end
                        cur_gain_reg <= s_payload.gain_enable ? s_payload.new_gain : UNITY_GAIN;
                        order_reg    <= new_p;
                    end
                    REQ_CLEAR: begin
                        for (int i = 0; i < TAP_LIMIT; i++) begin
                            hist_reg[i] <= '0;
                        end
                        fade_reg <= '0;
                    end
                    REQ_SAMPLE: begin
                        if (order_reg != '0) begin
                            c_reg <= fade_reg;
                            if (fade_reg != '0) begin
                                fade_reg <= fade_reg - 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (fin_fire && !pass_reg) begin
                for (int i = 0; i < TAP_LIMIT; i++) begin
                    if (diverge) begin
                        hist_reg[i] <= '0;
                    end else if (i == 0) begin
                        hist_reg[i] <= s32;
                    end else if (i < int'(order_reg)) begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                end
            end
        end
        if (accept) begin
            e_reg <= s_payload.excitation;
        end
        out_reg <= out_next;
    end

    lpcs_mac_unit #(
        .ACC_W(ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prod    (prod),
        .acc     (acc),
        .acc_busy(acc_busy)
    );

    lpcs_divider #(
        .DIVISOR(SMOOTH_LEN),
        .RW     (CW),
        .QW     (COEF_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(prod[CW+COEF_W-1:0]),
        .done    (div_done),
        .quotient(div_quo)
    );

endmodule
`default_nettype wire

// ----- src/lpcs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpcs_checker import lpcs_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_payload,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_payload
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result dropped or changed while stalled");

    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.req_type == REQ_SAMPLE |=> !s_ready)
        else $error("ready stayed high after sample request");

    a_ctrl_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.req_type != REQ_SAMPLE |=> s_ready)
        else $error("non-sample request stalled input");

    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.diverged |-> m_payload.out_sample == 32'sd0)
        else $error("diverged result not zero");

endmodule

bind lpc_allpole_synthesis_filter_top lpcs_checker u_chk (.*);
`default_nettype wire

// ----- tb/lpc_allpole_synthesis_filter_checker.sv -----
`timescale 1ns / 1ps
module lpc_allpole_synthesis_filter_checker import lpcs_pkg::*; #(
    parameter int TAP_LIMIT = 32,
    parameter int SMOOTH_LEN = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_t         s_payload,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_t        m_payload,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [30:0] cfg_data,
    output int               errors,
    output int               pending_results
);
    logic signed [23:0] pend_bank [TAP_LIMIT];
    logic signed [23:0] cur_bank [TAP_LIMIT];
    logic signed [23:0] prev_bank [TAP_LIMIT];
    logic signed [63:0] hist [TAP_LIMIT];
    logic signed [23:0] cur_gain, prev_gain;
    int unsigned order_now, fade_left;
    logic [30:0] div_limit;
    out_t sample_q [$];

    assign pending_results = sample_q.size();

    function automatic longint faded(longint now, longint prev, int unsigned c);
        if (c == 0) return now;
        return now + ((prev - now) * longint'(c)) / SMOOTH_LEN;
    endfunction

    function automatic longint floor16(longint x);
        if (x >= 0) return x >>> 16;
        return -(longint'((-(x + 1)) >>> 16)) - 1;
    endfunction

    task automatic synth_request(in_t r);
        int unsigned p, c;
        longint acc, s, mag;
        logic dv;
        out_t o;
        case (r.req_type)
            REQ_WRITE: begin
                if (r.coeff_index < TAP_LIMIT) pend_bank[r.coeff_index] = r.coeff_value;
            end
            REQ_COMMIT: begin
                p = r.new_order;
                if (p > TAP_LIMIT) p = TAP_LIMIT;
                if (r.smooth_enable && order_now > 0) begin
                    prev_bank = cur_bank;
                    prev_gain = cur_gain;
                    fade_left = SMOOTH_LEN;
                end else begin
                    fade_left = 0;
                end
                for (int i = 0; i < p; i++) cur_bank[i] = pend_bank[i];
                cur_gain = r.gain_enable ? r.new_gain : UNITY_GAIN;
                order_now = p;
            end
            REQ_CLEAR: begin
                foreach (hist[i]) hist[i] = 0;
                fade_left = 0;
            end
            default: begin
                if (order_now == 0) begin
                    o.out_sample = 32'(longint'(r.excitation));
                    o.diverged = 1'b0;
                end else begin
                    c = fade_left;
                    if (fade_left > 0) fade_left--;
                    acc = longint'(r.excitation) * faded(cur_gain, prev_gain, c);
                    for (int i = 0; i < order_now; i++)
                        acc -= faded(cur_bank[i], prev_bank[i], c) * hist[i];
                    s = floor16(acc);
                    mag = s < 0 ? -s : s;
                    dv = mag > longint'(div_limit) || s > 64'sd2147483647
                        || s < -64'sd2147483648;
                    if (dv) begin
                        s = 0;
                        foreach (hist[i]) hist[i] = 0;
                    end
                    for (int i = order_now - 1; i > 0; i--) hist[i] = hist[i - 1];
                    hist[0] = s;
                    o.out_sample = 32'(s);
                    o.diverged = dv;
                end
                sample_q.push_back(o);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (pend_bank[i]) begin
                pend_bank[i] <= '0;
                cur_bank[i] <= '0;
                prev_bank[i] <= '0;
                hist[i] <= '0;
            end
            cur_gain <= '0;
            prev_gain <= '0;
            order_now <= 0;
            fade_left <= 0;
            div_limit <= 31'h7FFFFFFF;
            sample_q.delete();
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready) div_limit = cfg_data;
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected result out_sample %0d", m_payload.out_sample);
                    errors <= errors + 1;
                end else begin
                    if (m_payload.out_sample !== sample_q[0].out_sample) begin
                        $error("out_sample expected %0d actual %0d",
                               sample_q[0].out_sample, m_payload.out_sample);
                        errors <= errors + 1;
                    end else if (m_payload.diverged !== sample_q[0].diverged) begin
                        $error("diverged expected %0d actual %0d",
                               sample_q[0].diverged, m_payload.diverged);
                        errors <= errors + 1;
                    end
                    void'(sample_q.pop_front());
                end
            end
            if (s_valid && s_ready) synth_request(s_payload);
        end
    end
endmodule

// ----- tb/lpc_allpole_synthesis_filter_top_test.sv -----
`timescale 1ns / 1ps
module lpc_allpole_synthesis_filter_top_test import lpcs_pkg::*;;
    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 0;
    out_t m_payload;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [30:0] cfg_data = '0;
    int errors, pending_results;
    int send_idle = 0, recv_stall = 0;

    always #5 aclk = ~aclk;

    lpc_allpole_synthesis_filter_top uut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_payload, .m_valid, .m_ready,
        .m_payload, .cfg_valid, .cfg_ready, .cfg_data
    );

    lpc_allpole_synthesis_filter_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_payload, .m_valid, .m_ready,
        .m_payload, .cfg_valid, .cfg_ready, .cfg_data, .errors, .pending_results
    );

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall);

    task automatic send(in_t r);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_payload <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_limit(logic [30:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_t rand_req(logic [1:0] kind);
        logic [95:0] bits;
        in_t r;
        bits = {$urandom, $urandom, $urandom};
        r = in_t'(bits[$bits(in_t)-1:0]);
        r.req_type = req_t'(kind);
        return r;
    endfunction

    task automatic send_kind(req_t k, int a, int b, int g, bit sm, bit ag);
        in_t r;
        r = rand_req(k);
        r.excitation = 24'(a);
        r.coeff_index = 5'(b);
        r.coeff_value = 24'(g);
        r.new_order = 6'(b);
        r.new_gain = 24'(g);
        r.smooth_enable = sm;
        r.gain_enable = ag;
        send(r);
    endtask

    task automatic random_frame();
        in_t r;
        int ord;
        ord = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(8);
        for (int i = 0; i < ord && i < 32; i++) begin
            r = rand_req(REQ_WRITE);
            r.coeff_index = 5'(i);
            r.coeff_value = ($urandom_range(3) == 0) ? r.coeff_value
                          : 24'($signed($urandom_range(16000)) - 8000);
            send(r);
        end
        r = rand_req(REQ_COMMIT);
        r.new_order = 6'(ord);
        if ($urandom_range(3) != 0) r.new_gain = 24'($urandom_range(131072));
        send(r);
        repeat ($urandom_range(40, 5)) begin
            r = rand_req(($urandom_range(19) == 0) ? 2'($urandom_range(3)) : REQ_SAMPLE);
            send(r);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_kind(REQ_SAMPLE, 8388607, 0, 0, 0, 0);
        send_kind(REQ_SAMPLE, -8388608, 0, 0, 0, 0);
        send_kind(REQ_WRITE, 0, 0, 8388607, 0, 0);
        send_kind(REQ_WRITE, 0, 31, -8388608, 0, 0);
        send_kind(REQ_WRITE, 0, 1, 30000, 0, 0);
        send_kind(REQ_COMMIT, 0, 63, -8388608, 0, 1);
        send_kind(REQ_SAMPLE, 8388607, 0, 0, 0, 0);
        send_kind(REQ_SAMPLE, -8388608, 0, 0, 0, 0);
        send_kind(REQ_COMMIT, 0, 2, 8388607, 1, 1);
        send_kind(REQ_SAMPLE, 8388607, 0, 0, 0, 0);
        send_kind(REQ_SAMPLE, 1000, 0, 0, 0, 0);
        send_kind(REQ_CLEAR, 0, 0, 0, 0, 0);
        send_kind(REQ_SAMPLE, -1, 0, 0, 0, 0);
        send_kind(REQ_COMMIT, 0, 0, 0, 1, 0);
        send_kind(REQ_SAMPLE, 5, 0, 0, 0, 0);
        send_kind(REQ_COMMIT, 0, 1, 0, 0, 0);
        send_kind(REQ_SAMPLE, 12345, 0, 0, 0, 0);
        drain();
        write_limit(31'd0);
        send_kind(REQ_SAMPLE, 100, 0, 0, 0, 0);
        send_kind(REQ_SAMPLE, 0, 0, 0, 0, 0);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 81; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 81; end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            write_limit(ph == 7 ? 31'h7FFFFFFF : 31'($urandom_range(ph * 4 + 1) << 20));
            repeat (7) random_frame();
            drain();
        end
        if (errors == 0)
            $display("lpc_allpole_synthesis_filter_top_test OK");
        else
            $display("lpc_allpole_synthesis_filter_top_test NOT OK");
        $finish;
    end

    initial begin
        #50ms;
        $display("lpc_allpole_synthesis_filter_top_test NOT OK");
        $finish;
    end
endmodule
